/* rtl/fsr_pkg.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// Fan speed regulator package
// Shared widths, reset values, operation codes and register indexes.
// ----------------------------------------------------------------------------
package fsr_pkg;

	localparam int TEMP_W     = 10;
	localparam int DUTY_W     = 8;
	localparam int CFG_DATA_W = 10;
	localparam int MAG_W      = 19;
	localparam int DIVR_W     = 10;
	localparam int DIV_CNT_W  = 5;
	localparam int HYST_SHIFT = 3;

	localparam logic [DUTY_W-1:0] TARGET_RESET = 8'd24;
	localparam logic [DUTY_W-1:0] OUTPUT_RESET = 8'd64;
	localparam logic signed [TEMP_W-1:0] TEMP_LOW_RESET  = 10'sd160;
	localparam logic signed [TEMP_W-1:0] TEMP_HIGH_RESET = 10'sd240;
	localparam logic [DUTY_W-1:0] DUTY_MIN_RESET = 8'd24;
	localparam logic [DUTY_W-1:0] DUTY_MAX_RESET = 8'd160;

	localparam logic OP_TEMP = 1'b0;
	localparam logic OP_TICK = 1'b1;

	typedef enum logic [1:0] {
		REG_TEMP_LOW  = 2'd0,
		REG_TEMP_HIGH = 2'd1,
		REG_DUTY_MIN  = 2'd2,
		REG_DUTY_MAX  = 2'd3
	} reg_idx_t;

	typedef struct packed {
		logic start;
		logic done;
	} div_ctl_t;

endpackage
`default_nettype wire

/* rtl/fsr_div.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// Fan speed regulator divider
// Restoring unsigned divider, one quotient bit per cycle.
// ----------------------------------------------------------------------------
module fsr_div (
	input  wire logic                      clk,
	input  wire logic                      arst_n,
	input  wire logic                      start,
	input  wire logic [fsr_pkg::MAG_W-1:0] dividend,
	input  wire logic [fsr_pkg::DIVR_W-1:0] divisor,
	output logic                           done,
	output logic [fsr_pkg::MAG_W-1:0]      quotient
);
	import fsr_pkg::*;

	logic [DIVR_W-1:0]    rem_q;
	logic [MAG_W-1:0]     quo_q;
	logic [DIV_CNT_W-1:0] cnt_q;
	logic                 done_q;
	logic [DIVR_W:0]      trial;
	logic                 fits;

	assign trial = {rem_q, quo_q[MAG_W-1]};
	assign fits  = trial >= {1'b0, divisor};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q  <= '0;
			done_q <= 1'b0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				cnt_q <= DIV_CNT_W'(MAG_W);
			end else if (cnt_q != '0) begin
				cnt_q <= cnt_q - 1'b1;
				if (cnt_q == DIV_CNT_W'(1)) begin
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			rem_q <= '0;
			quo_q <= dividend;
		end else if (cnt_q != '0) begin
			rem_q <= fits ? DIVR_W'(trial - {1'b0, divisor}) : trial[DIVR_W-1:0];
			quo_q <= {quo_q[MAG_W-2:0], fits};
		end
	end

	assign done     = done_q;
	assign quotient = quo_q;

endmodule
`default_nettype wire

/* rtl/fan_speed_regulator_hysteresis.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// Fan speed regulator with hysteresis and slew limiting
// Maps the hotter of two temperature readings onto a fan duty target and
// steps the output duty toward that target on each tick.
// ----------------------------------------------------------------------------
// A tick item goes straight to the done state and keeps the block busy until
// it is ready again. A temperature item ends early when the window is empty,
// after one divider pass when the target rises, and after a second divider
// pass when the hysteresis bound is evaluated as well; the serial divider,
// used once per bound, sets the time a temperature item takes. The block takes
// one item at a time and is not ready while an item is at work; a finished
// result waits in the output register while the next item is taken.
module fan_speed_regulator_hysteresis (
	input  wire logic                            clk,
	input  wire logic                            arst_n,
	input  wire logic                            s_axis_tvalid,
	output logic                                 s_axis_tready,
	// temp_a [9:0], temp_b [19:10], zero fill [23:20]
	input  wire logic [23:0]                     s_axis_tdata,
	// op [0]
	input  wire logic                            s_axis_tuser,
	output logic                                 m_axis_tvalid,
	input  wire logic                            m_axis_tready,
	// duty [7:0], target [15:8]
	output logic [15:0]                          m_axis_tdata,
	input  wire logic                            cfg_valid,
	output logic                                 cfg_ready,
	input  wire fsr_pkg::reg_idx_t               cfg_index,
	input  wire logic [fsr_pkg::CFG_DATA_W-1:0]  cfg_data
);
	import fsr_pkg::*;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_PREP,
		ST_MUL,
		ST_DIVS,
		ST_DIV,
		ST_EVAL,
		ST_DONE
	} state_t;

	state_t state_q;

	logic signed [TEMP_W-1:0] temp_low_q;
	logic signed [TEMP_W-1:0] temp_high_q;
	logic [DUTY_W-1:0]        duty_min_q;
	logic [DUTY_W-1:0]        duty_max_q;
	logic [DUTY_W-1:0]        target_q;
	logic [DUTY_W-1:0]        duty_q;

	logic signed [TEMP_W-1:0] t_q;
	logic                     pass_q;
	logic signed [TEMP_W:0]   win_q;
	logic signed [DUTY_W:0]   span_q;
	logic signed [TEMP_W+1:0] d_q;
	logic signed [20:0]       prod_q;
	logic                     m_valid_q;
	logic [15:0]              m_data_q;

	logic signed [TEMP_W-1:0] temp_a;
	logic signed [TEMP_W-1:0] temp_b;
	logic                     in_xfer;
	logic [20:0]              prod_abs;
	logic                     div_start;
	logic                     div_done;
	logic [MAG_W-1:0]         quo;
	logic signed [MAG_W:0]    q_s;
	logic signed [20:0]       m_val;
	logic signed [20:0]       cur;
	logic signed [20:0]       dmin_x;
	logic signed [20:0]       dmax_x;
	logic signed [TEMP_W+1:0] hyst;

	assign temp_a  = s_axis_tdata[9:0];
	assign temp_b  = s_axis_tdata[19:10];
	assign in_xfer = s_axis_tvalid && s_axis_tready;

	assign s_axis_tready = (state_q == ST_IDLE);
	assign cfg_ready     = 1'b1;
	assign m_axis_tvalid = m_valid_q;
	assign m_axis_tdata  = m_data_q;

	assign prod_abs  = prod_q[20] ? 21'(-prod_q) : prod_q;
	assign div_start = (state_q == ST_DIVS);

	fsr_div u_div (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (div_start),
		.dividend (prod_abs[MAG_W-1:0]),
		.divisor  (win_q[DIVR_W-1:0]),
		.done     (div_done),
		.quotient (quo)
	);

	assign q_s    = prod_q[20] ? -$signed({1'b0, quo}) : $signed({1'b0, quo});
	assign dmin_x = $signed({13'd0, duty_min_q});
	assign dmax_x = $signed({13'd0, duty_max_q});
	assign cur    = $signed({13'd0, target_q});
	assign m_val  = $signed({q_s[MAG_W], q_s}) + dmin_x;
	assign hyst   = $signed({{(HYST_SHIFT + 2){1'b0}}, win_q[TEMP_W-1:HYST_SHIFT]});

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			temp_low_q  <= TEMP_LOW_RESET;
			temp_high_q <= TEMP_HIGH_RESET;
			duty_min_q  <= DUTY_MIN_RESET;
			duty_max_q  <= DUTY_MAX_RESET;
			target_q    <= TARGET_RESET;
			duty_q      <= OUTPUT_RESET;
			m_valid_q   <= 1'b0;
			m_data_q    <= '0;
			pass_q      <= 1'b0;
			t_q         <= '0;
			win_q       <= '0;
			span_q      <= '0;
			d_q         <= '0;
			prod_q      <= '0;
		end else begin
			if (cfg_valid && cfg_ready) begin
				case (cfg_index)
					REG_TEMP_LOW:  temp_low_q  <= cfg_data[TEMP_W-1:0];
					REG_TEMP_HIGH: temp_high_q <= cfg_data[TEMP_W-1:0];
					REG_DUTY_MIN:  duty_min_q  <= cfg_data[DUTY_W-1:0];
					REG_DUTY_MAX:  duty_max_q  <= cfg_data[DUTY_W-1:0];
					default: ;
				endcase
			end

			if (m_valid_q && m_axis_tready && (state_q != ST_DONE)) begin
				m_valid_q <= 1'b0;
			end

			case (state_q)
				ST_IDLE: begin
					if (in_xfer) begin
						if (s_axis_tuser == OP_TICK) begin
							if (duty_q < target_q) begin
								duty_q <= duty_q + 1'b1;
							end else if (duty_q > target_q) begin
								duty_q <= duty_q - 1'b1;
							end
							state_q <= ST_DONE;
						end else begin
							t_q     <= (temp_b > temp_a) ? temp_b : temp_a;
							state_q <= ST_PREP;
						end
					end
				end
				ST_PREP: begin
					win_q  <= {temp_high_q[TEMP_W-1], temp_high_q}
						- {temp_low_q[TEMP_W-1], temp_low_q};
					span_q <= $signed({1'b0, duty_max_q}) - $signed({1'b0, duty_min_q});
					d_q    <= {{2{t_q[TEMP_W-1]}}, t_q} - {{2{temp_low_q[TEMP_W-1]}}, temp_low_q};
					pass_q <= 1'b0;
					state_q <= ST_MUL;
				end
				ST_MUL: begin
					if (win_q[TEMP_W] || (win_q == '0)) begin
						target_q <= duty_max_q;
						state_q  <= ST_DONE;
					end else begin
						prod_q  <= $signed({{9{d_q[TEMP_W+1]}}, d_q})
							* $signed({{12{span_q[DUTY_W]}}, span_q});
						state_q <= ST_DIVS;
					end
				end
				ST_DIVS: begin
					state_q <= ST_DIV;
				end
				ST_DIV: begin
					if (div_done) begin
						state_q <= ST_EVAL;
					end
				end
				ST_EVAL: begin
					if (!pass_q) begin
						if (m_val > cur) begin
							target_q <= (m_val > dmax_x) ? duty_max_q : m_val[DUTY_W-1:0];
							state_q  <= ST_DONE;
						end else begin
							d_q     <= d_q + hyst;
							pass_q  <= 1'b1;
							state_q <= ST_MUL;
						end
					end else begin
						if (m_val < cur) begin
							target_q <= (m_val < dmin_x) ? duty_min_q : m_val[DUTY_W-1:0];
						end
						state_q <= ST_DONE;
					end
				end
				ST_DONE: begin
					if (!m_valid_q || m_axis_tready) begin
						m_valid_q <= 1'b1;
						m_data_q  <= {target_q, duty_q};
						state_q   <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

endmodule
`default_nettype wire

/* rtl/fsr_chk.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// Fan speed regulator port checker
// Watches the stream ports of the regulator for ordering and stall rules.
// ----------------------------------------------------------------------------
module fsr_chk (
	input wire logic        clk,
	input wire logic        arst_n,
	input wire logic        s_axis_tvalid,
	input wire logic        s_axis_tready,
	input wire logic        m_axis_tvalid,
	input wire logic        m_axis_tready,
	input wire logic [15:0] m_axis_tdata
);
	import fsr_pkg::*;

	// A stalled result keeps its data.
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		(m_axis_tvalid && !m_axis_tready) |=> (m_axis_tvalid && $stable(m_axis_tdata)))
		else $error("result changed while stalled");

	// After an input transfer the block works on that item and takes no other.
	a_busy: assert property (@(posedge clk) disable iff (!arst_n)
		(s_axis_tvalid && s_axis_tready) |=> !s_axis_tready)
		else $error("input taken while busy");

	// A new result is only presented at the end of a busy period.
	a_result_after_work: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(m_axis_tvalid) |-> !$past(s_axis_tready))
		else $error("result without work");

	// A result follows every input transfer before the block is ready again.
	a_ready_after_result: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(s_axis_tready) |-> m_axis_tvalid)
		else $error("ready again without a result");

endmodule

bind fan_speed_regulator_hysteresis fsr_chk u_fsr_chk (
	.clk           (clk),
	.arst_n        (arst_n),
	.s_axis_tvalid (s_axis_tvalid),
	.s_axis_tready (s_axis_tready),
	.m_axis_tvalid (m_axis_tvalid),
	.m_axis_tready (m_axis_tready),
	.m_axis_tdata  (m_axis_tdata)
);
`default_nettype wire

/* test/testbench.sv */
// ----------------------------------------------------------------------------
// Fan speed regulator testbench
// Sends temperature and tick transfers through the stream ports, under
// several register settings and flow-control patterns. Each result is
// checked against an in-bench prediction of the target and output duty.
// ----------------------------------------------------------------------------
module testbench;
	import fsr_pkg::*;

	typedef struct packed {
		logic [DUTY_W-1:0] target;
		logic [DUTY_W-1:0] duty;
	} duty_pair_t;

	class fan_duty_tracker;
		int temp_low = 160;
		int temp_high = 240;
		int duty_min = 24;
		int duty_max = 160;
		logic [DUTY_W-1:0] target_duty = TARGET_RESET;
		logic [DUTY_W-1:0] output_duty = OUTPUT_RESET;
		duty_pair_t expected_duty_q[$];
		int errors = 0;

		function void set_reg(reg_idx_t idx, logic [CFG_DATA_W-1:0] data);
			case (idx)
				REG_TEMP_LOW: temp_low = int'($signed(data));
				REG_TEMP_HIGH: temp_high = int'($signed(data));
				REG_DUTY_MIN: duty_min = int'(data[DUTY_W-1:0]);
				REG_DUTY_MAX: duty_max = int'(data[DUTY_W-1:0]);
				default: ;
			endcase
		endfunction

		function void regulate_target(int t);
			int win;
			int span;
			int cur;
			int m;
			win = temp_high - temp_low;
			span = duty_max - duty_min;
			cur = int'(target_duty);
			if (win <= 0) begin
				target_duty = 8'(duty_max);
				return;
			end
			m = ((t - temp_low) * span) / win + duty_min;
			if (m > cur) begin
				target_duty = 8'((m > duty_max) ? duty_max : m);
				return;
			end
			m = ((t - temp_low + (win >>> HYST_SHIFT)) * span) / win + duty_min;
			if (m < cur)
				target_duty = 8'((m < duty_min) ? duty_min : m);
		endfunction

		function void take_item(logic op, logic signed [TEMP_W-1:0] a,
				logic signed [TEMP_W-1:0] b);
			duty_pair_t exp_pair;
			if (op == OP_TICK) begin
				if (output_duty < target_duty)
					output_duty = output_duty + 8'd1;
				else if (output_duty > target_duty)
					output_duty = output_duty - 8'd1;
			end else begin
				regulate_target((b > a) ? int'(b) : int'(a));
			end
			exp_pair.duty = output_duty;
			exp_pair.target = target_duty;
			expected_duty_q.push_back(exp_pair);
		endfunction

		function void check_duty(logic [15:0] data);
			duty_pair_t got;
			duty_pair_t exp_pair;
			got = data;
			if (expected_duty_q.size() == 0) begin
				$display("%0t: unexpected result, duty %0d target %0d", $time,
					got.duty, got.target);
				errors++;
				return;
			end
			exp_pair = expected_duty_q.pop_front();
			if (got.duty !== exp_pair.duty) begin
				$display("%0t: duty expected %0d, got %0d", $time, exp_pair.duty, got.duty);
				errors++;
			end
			if (got.target !== exp_pair.target) begin
				$display("%0t: target expected %0d, got %0d", $time, exp_pair.target,
					got.target);
				errors++;
			end
		endfunction

		function int pending_count();
			return expected_duty_q.size();
		endfunction
	endclass

	logic clk;
	logic arst_n;
	logic s_axis_tvalid;
	logic s_axis_tready;
	logic [23:0] s_axis_tdata;
	logic s_axis_tuser;
	logic m_axis_tvalid;
	logic m_axis_tready;
	logic [15:0] m_axis_tdata;
	logic cfg_valid;
	logic cfg_ready;
	reg_idx_t cfg_index;
	logic [CFG_DATA_W-1:0] cfg_data;

	int send_idle_pct = 0;
	int rx_stall_pct = 0;
	fan_duty_tracker sb = new();

	fan_speed_regulator_hysteresis dut (
		.clk(clk),
		.arst_n(arst_n),
		.s_axis_tvalid(s_axis_tvalid),
		.s_axis_tready(s_axis_tready),
		.s_axis_tdata(s_axis_tdata),
		.s_axis_tuser(s_axis_tuser),
		.m_axis_tvalid(m_axis_tvalid),
		.m_axis_tready(m_axis_tready),
		.m_axis_tdata(m_axis_tdata),
		.cfg_valid(cfg_valid),
		.cfg_ready(cfg_ready),
		.cfg_index(cfg_index),
		.cfg_data(cfg_data)
	);

	initial begin
		clk = 1'b0;
		forever #10 clk = ~clk;
	end

	initial begin
		#30_000_000;
		$display("[FAIL] regression broken");
		$finish;
	end

	always @(posedge clk) begin
		m_axis_tready <= ($urandom_range(99) >= rx_stall_pct);
	end

	always @(posedge clk) begin
		if (arst_n && m_axis_tvalid && m_axis_tready)
			sb.check_duty(m_axis_tdata);
	end

	task automatic write_reg(input reg_idx_t idx, input logic [CFG_DATA_W-1:0] data);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data <= data;
		@(posedge clk);
		while (!cfg_ready)
			@(posedge clk);
		sb.set_reg(idx, data);
	endtask

	task automatic configure(input int t_low, input int t_high, input int d_min,
			input int d_max);
		write_reg(REG_TEMP_LOW, 10'(t_low));
		write_reg(REG_TEMP_HIGH, 10'(t_high));
		write_reg(REG_DUTY_MIN, {2'($urandom), 8'(d_min)});
		write_reg(REG_DUTY_MAX, {2'($urandom), 8'(d_max)});
		cfg_valid <= 1'b0;
	endtask

	task automatic send_item(input logic op, input logic signed [TEMP_W-1:0] a,
			input logic signed [TEMP_W-1:0] b);
		while ($urandom_range(99) < send_idle_pct) begin
			s_axis_tvalid <= 1'b0;
			@(posedge clk);
		end
		s_axis_tvalid <= 1'b1;
		s_axis_tuser <= op;
		s_axis_tdata <= {4'b0000, b, a};
		@(posedge clk);
		while (!s_axis_tready)
			@(posedge clk);
		sb.take_item(op, a, b);
	endtask

	task automatic send_random_item();
		int lo;
		int hi;
		int t;
		int other;
		logic op;
		logic signed [TEMP_W-1:0] a;
		logic signed [TEMP_W-1:0] b;
		op = ($urandom_range(99) < 55) ? OP_TICK : OP_TEMP;
		a = 10'($urandom);
		b = 10'($urandom);
		if (op == OP_TEMP && $urandom_range(99) < 70) begin
			lo = ((sb.temp_low < sb.temp_high) ? sb.temp_low : sb.temp_high) - 16;
			hi = ((sb.temp_low < sb.temp_high) ? sb.temp_high : sb.temp_low) + 16;
			if (lo < -512)
				lo = -512;
			if (hi > 511)
				hi = 511;
			t = lo + int'($urandom_range(hi - lo));
			other = -512 + int'($urandom_range(t + 512));
			if ($urandom_range(1) == 1) begin
				a = 10'(t);
				b = 10'(other);
			end else begin
				a = 10'(other);
				b = 10'(t);
			end
		end
		send_item(op, a, b);
	endtask

	task automatic drain();
		s_axis_tvalid <= 1'b0;
		while (sb.pending_count() != 0)
			@(posedge clk);
		repeat (4) @(posedge clk);
	endtask

	initial begin
		arst_n <= 1'b0;
		s_axis_tvalid <= 1'b0;
		s_axis_tdata <= '0;
		s_axis_tuser <= OP_TEMP;
		m_axis_tready <= 1'b0;
		cfg_valid <= 1'b0;
		cfg_index <= REG_TEMP_LOW;
		cfg_data <= '0;
		repeat (12) @(posedge clk);
		arst_n <= 1'b1;
		repeat (2) @(posedge clk);

		send_item(OP_TICK, -10'sd1, -10'sd512);
		send_item(OP_TEMP, 10'sd511, -10'sd512);
		send_item(OP_TEMP, -10'sd512, 10'sd511);
		send_item(OP_TICK, 10'sd511, 10'sd511);
		send_item(OP_TEMP, -10'sd512, -10'sd512);
		send_item(OP_TEMP, 10'sd200, 10'sd180);
		send_item(OP_TEMP, 10'sd190, 10'sd195);
		send_item(OP_TEMP, 10'sd150, 10'sd170);
		send_item(OP_TEMP, 10'sd0, -10'sd1);
		send_item(OP_TICK, 10'sd0, 10'sd0);
		drain();
		configure(200, 200, 24, 160);
		send_item(OP_TEMP, -10'sd512, -10'sd512);
		drain();
		configure(511, -512, 30, 90);
		send_item(OP_TEMP, 10'sd0, 10'sd0);
		send_item(OP_TICK, -10'sd256, 10'sd255);
		drain();
		configure(160, 240, 200, 40);
		send_item(OP_TEMP, 10'sd160, 10'sd100);
		send_item(OP_TEMP, 10'sd240, 10'sd0);
		send_item(OP_TEMP, 10'sd200, 10'sd200);
		send_item(OP_TEMP, -10'sd512, -10'sd512);
		send_item(OP_TICK, 10'sd1, 10'sd2);
		drain();
		configure(-512, 511, 0, 255);
		send_item(OP_TEMP, -10'sd512, -10'sd512);
		send_item(OP_TEMP, 10'sd511, 10'sd0);
		send_item(OP_TEMP, 10'sd0, 10'sd511);
		send_item(OP_TEMP, 10'sd255, -10'sd256);
		send_item(OP_TICK, 10'sd0, 10'sd0);
		send_item(OP_TICK, -10'sd1, -10'sd1);

		for (int p = 0; p < 10; p++) begin
			drain();
			case (p)
				0: configure(160, 240, 24, 160);
				1: configure(-512, 511, 0, 255);
				2: configure(0, 400, 220, 40);
				3: configure(300, -300, 24, 160);
				4: configure(-20, -13, 10, 250);
				5: configure(0, 511, 128, 128);
				6: configure(160, 240, 0, 255);
				default: configure(int'($urandom_range(1023)) - 512,
					int'($urandom_range(1023)) - 512,
					int'($urandom_range(255)), int'($urandom_range(255)));
			endcase
			case (p % 4)
				0: begin
					send_idle_pct = 0;
					rx_stall_pct <= 0;
				end
				1: begin
					send_idle_pct = 86;
					rx_stall_pct <= 0;
				end
				2: begin
					send_idle_pct = 0;
					rx_stall_pct <= 86;
				end
				default: begin
					send_idle_pct = 26;
					rx_stall_pct <= 26;
				end
			endcase
			repeat (65) send_random_item();
		end

		drain();
		repeat (60) @(posedge clk);
		if (sb.errors == 0 && sb.pending_count() == 0)
			$display("[ OK ] regression clean");
		else
			$display("[FAIL] regression broken");
		$finish;
	end

endmodule
